// ----- design/swfc_pkg.sv -----
// Shared codes, types and fixed constants of the sweep free-run coalescer.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package swfc_pkg;

    // Result kinds on the output channel
    localparam logic [1:0] KIND_FREE    = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_WHOLE   = 2'd2;

    // Page-end action carried in a queue entry
    localparam logic [1:0] FIN_NONE    = 2'd0;
    localparam logic [1:0] FIN_SUMMARY = 2'd1;
    localparam logic [1:0] FIN_WHOLE   = 2'd2;

    // Configuration register indexes
    localparam int         CFG_INDEX_BITS   = 3;
    localparam logic [2:0] REG_PAGE_START   = 3'd0;
    localparam logic [2:0] REG_EXEC_PAGE    = 3'd1;
    localparam logic [2:0] REG_RELEASE_EN   = 3'd2;
    localparam logic [2:0] REG_OS_PAGE_LOG2 = 3'd3;
    localparam logic [2:0] REG_FREE_HEADER  = 3'd4;

    localparam logic [4:0] OS_PAGE_LOG2_RESET = 5'd12;
    localparam logic [7:0] FREE_HEADER_RESET  = 8'd32;

    // Queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       exec_page;
        logic       release_en;
        logic [4:0] os_page_log2;
        logic [7:0] header_bytes;
    } cfg_t;

    // What one accepted item asks the back part to emit
    typedef struct packed {
        logic       blk;
        logic [1:0] fin;
    } ctl_t;

endpackage

`default_nettype wire

// ----- design/swfc_front.sv -----
// Front part: configuration registers, address cursor, run tracking and
// item classification into queue entries. Depends on swfc_pkg.
`default_nettype none

module swfc_front #(
    parameter int ADDR_BITS = 48,
    parameter int SIZE_BITS = 32
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [swfc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire  [ADDR_BITS-1:0]                   cfg_data,
    input  wire                                    item_valid,
    output logic                                   item_ready,
    input  wire  [SIZE_BITS-1:0]                   object_bytes,
    input  wire                                    marked,
    input  wire                                    page_last,
    output swfc_pkg::cfg_t                         cfg,
    input  wire                                    q_ready,
    output logic                                   q_push,
    output swfc_pkg::ctl_t                         ent_ctl,
    output logic [ADDR_BITS-1:0]                   ent_start,
    output logic [ADDR_BITS-1:0]                   ent_end,
    output logic [SIZE_BITS-1:0]                   ent_live
);

    localparam int MW = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;

    logic [ADDR_BITS-1:0] page_start_reg;
    logic [ADDR_BITS-1:0] cursor_reg;
    logic [ADDR_BITS-1:0] cursor_next;
    logic [ADDR_BITS-1:0] run_start_reg;
    logic [ADDR_BITS-1:0] run_start_after;
    logic                 run_open_reg;
    logic [SIZE_BITS-1:0] live_reg;
    logic [SIZE_BITS-1:0] live_next;
    logic [SIZE_BITS:0]   live_sum;
    logic [MW-1:0]        addr_sum;
    swfc_pkg::cfg_t       cfg_reg;
    logic                 cfg_fire;
    logic                 item_fire;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign item_ready = q_ready;
    assign item_fire  = item_valid && item_ready;
    assign cfg        = cfg_reg;

    // Advance the cursor and the saturating live total
    always_comb
    begin
        addr_sum    = MW'(cursor_reg) + MW'(object_bytes);
        cursor_next = addr_sum[ADDR_BITS-1:0];
        live_sum    = {1'b0, live_reg} + {1'b0, object_bytes};
        if (!marked)
        begin
            live_next = live_reg;
        end
        else if (live_sum[SIZE_BITS])
        begin
            live_next = '1;
        end
        else
        begin
            live_next = live_sum[SIZE_BITS-1:0];
        end
        run_start_after = (!marked && !run_open_reg) ? cursor_reg : run_start_reg;
    end

    // Classify the item: closed run, page-end block, summary or wholly free
    always_comb
    begin
        ent_ctl.blk = marked && run_open_reg;
        ent_ctl.fin = swfc_pkg::FIN_NONE;
        ent_start   = run_start_reg;
        ent_end     = cursor_reg;
        ent_live    = live_next;
        if (page_last)
        begin
            if (!marked && run_start_after == page_start_reg)
            begin
                ent_ctl.fin = swfc_pkg::FIN_WHOLE;
                ent_start   = run_start_after;
                ent_end     = cursor_next;
            end
            else if (!marked)
            begin
                ent_ctl.blk = 1'b1;
                ent_ctl.fin = swfc_pkg::FIN_SUMMARY;
                ent_start   = run_start_after;
                ent_end     = cursor_next;
            end
            else
            begin
                ent_ctl.fin = swfc_pkg::FIN_SUMMARY;
            end
        end
        q_push = item_fire && (ent_ctl.blk || ent_ctl.fin != swfc_pkg::FIN_NONE);
    end

    // Hold configuration and page state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_start_reg       <= '0;
            cfg_reg.exec_page    <= 1'b0;
            cfg_reg.release_en   <= 1'b0;
            cfg_reg.os_page_log2 <= swfc_pkg::OS_PAGE_LOG2_RESET;
            cfg_reg.header_bytes <= swfc_pkg::FREE_HEADER_RESET;
            cursor_reg           <= '0;
            run_start_reg        <= '0;
            run_open_reg         <= 1'b0;
            live_reg             <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                swfc_pkg::REG_PAGE_START:
                begin
                    page_start_reg <= cfg_data;
                    cursor_reg     <= cfg_data;
                    run_start_reg  <= '0;
                    run_open_reg   <= 1'b0;
                    live_reg       <= '0;
                end
                swfc_pkg::REG_EXEC_PAGE:    cfg_reg.exec_page    <= cfg_data[0];
                swfc_pkg::REG_RELEASE_EN:   cfg_reg.release_en   <= cfg_data[0];
                swfc_pkg::REG_OS_PAGE_LOG2: cfg_reg.os_page_log2 <= cfg_data[4:0];
                swfc_pkg::REG_FREE_HEADER:  cfg_reg.header_bytes <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
        else if (item_fire)
        begin
            if (page_last)
            begin
                cursor_reg    <= page_start_reg;
                run_start_reg <= '0;
                run_open_reg  <= 1'b0;
                live_reg      <= '0;
            end
            else
            begin
                cursor_reg    <= cursor_next;
                run_start_reg <= run_start_after;
                run_open_reg  <= !marked;
                live_reg      <= live_next;
            end
        end
    end

    a_page_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && page_last |=>
            cursor_reg == page_start_reg && !run_open_reg && live_reg == '0)
        else $error("page state not restarted after page end");

endmodule

`default_nettype wire

// ----- design/swfc_queue.sv -----
// Short register queue between front and back parts.
// Depends on swfc_pkg for depth and pointer widths.
`default_nettype none

module swfc_queue #(
    parameter int WIDTH = 131
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire  [WIDTH-1:0] push_data,
    output logic             ready,
    input  wire              pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0]                    mem_reg [swfc_pkg::QUEUE_DEPTH];
    logic [swfc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [swfc_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [swfc_pkg::QUEUE_CNT_BITS-1:0] count_reg;
    logic [swfc_pkg::QUEUE_CNT_BITS-1:0] count_next;

    assign ready = count_reg != swfc_pkg::QUEUE_CNT_BITS'(swfc_pkg::QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != swfc_pkg::QUEUE_CNT_BITS'(swfc_pkg::QUEUE_DEPTH))
        else $error("queue written while full");

endmodule

`default_nettype wire

// ----- design/swfc_back.sv -----
// Back part: expands queue entries into results, computes lengths and the
// OS-page-aligned release range over two stages, holds the output register.
// Depends on swfc_pkg.
`default_nettype none

module swfc_back #(
    parameter int ADDR_BITS = 48,
    parameter int SIZE_BITS = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire  swfc_pkg::cfg_t cfg,
    input  wire                  q_valid,
    input  wire  swfc_pkg::ctl_t q_ctl,
    input  wire  [ADDR_BITS-1:0] q_start,
    input  wire  [ADDR_BITS-1:0] q_end,
    input  wire  [SIZE_BITS-1:0] q_live,
    output logic                 q_pop,
    output logic                 result_valid,
    input  wire                  result_ready,
    output logic [1:0]           kind,
    output logic [ADDR_BITS-1:0] block_start,
    output logic [SIZE_BITS-1:0] block_bytes,
    output logic                 fill_break,
    output logic [ADDR_BITS-1:0] release_start,
    output logic [SIZE_BITS-1:0] release_bytes,
    output logic [SIZE_BITS-1:0] live_bytes,
    output logic                 last
);

    localparam int MW = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;

    function automatic logic [SIZE_BITS-1:0] sat_len(input logic [ADDR_BITS-1:0] v);
        logic [MW-1:0] w;
        w = MW'(v);
        return ((w >> SIZE_BITS) != '0) ? '1 : w[SIZE_BITS-1:0];
    endfunction

    // Issue
    logic                 phase_reg;
    logic                 first_op;
    logic                 op_final;
    logic                 issue;
    logic [1:0]           op_kind;
    logic [ADDR_BITS-1:0] op_start;
    logic [ADDR_BITS-1:0] op_end;
    logic [SIZE_BITS-1:0] op_live;

    // Stage 1
    logic                 s1_valid_reg;
    logic                 s1_ready;
    logic [1:0]           s1_kind_reg;
    logic [ADDR_BITS-1:0] s1_start_reg;
    logic [ADDR_BITS-1:0] s1_end_reg;
    logic [SIZE_BITS-1:0] s1_live_reg;
    logic                 s1_last_reg;
    logic [ADDR_BITS:0]   s1_a_reg;
    logic [ADDR_BITS-1:0] s1_len_reg;
    logic                 s1_ge_reg;
    logic                 s1_rel_reg;

    // Stage 2
    logic                 s2_valid_reg;
    logic                 s2_ready;
    logic [1:0]           s2_kind_reg;
    logic [ADDR_BITS-1:0] s2_start_reg;
    logic [SIZE_BITS-1:0] s2_len_reg;
    logic [SIZE_BITS-1:0] s2_live_reg;
    logic                 s2_last_reg;
    logic                 s2_fill_reg;
    logic                 s2_chk_reg;
    logic [ADDR_BITS:0]   s2_up_reg;
    logic [ADDR_BITS-1:0] s2_down_reg;
    logic [31:0]          pg_mask;

    // Output register
    logic                 out_valid_reg;
    logic                 out_ready;
    logic [1:0]           out_kind_reg;
    logic [ADDR_BITS-1:0] out_start_reg;
    logic [SIZE_BITS-1:0] out_bytes_reg;
    logic                 out_fill_reg;
    logic [ADDR_BITS-1:0] out_rstart_reg;
    logic [SIZE_BITS-1:0] out_rbytes_reg;
    logic [SIZE_BITS-1:0] out_live_reg;
    logic                 out_last_reg;
    logic [ADDR_BITS:0]   diff;
    logic                 rel_ok;

    assign out_ready = !out_valid_reg || result_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pg_mask   = (32'd1 << cfg.os_page_log2) - 32'd1;

    // Pick the next result of the head entry: free block first, then page end
    always_comb
    begin
        first_op = q_ctl.blk && !phase_reg;
        op_final = !(first_op && q_ctl.fin != swfc_pkg::FIN_NONE);
        if (first_op)
        begin
            op_kind = swfc_pkg::KIND_FREE;
        end
        else if (q_ctl.fin == swfc_pkg::FIN_WHOLE)
        begin
            op_kind = swfc_pkg::KIND_WHOLE;
        end
        else
        begin
            op_kind = swfc_pkg::KIND_SUMMARY;
        end
        if (op_kind == swfc_pkg::KIND_SUMMARY)
        begin
            op_start = '0;
            op_end   = '0;
            op_live  = q_live;
        end
        else
        begin
            op_start = q_start;
            op_end   = q_end;
            op_live  = '0;
        end
        issue = q_valid && s1_ready;
        q_pop = issue && op_final;
    end

    // Stage 1: header offset, raw length, wrap check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                phase_reg <= !op_final;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_kind_reg  <= op_kind;
            s1_start_reg <= op_start;
            s1_end_reg   <= op_end;
            s1_live_reg  <= op_live;
            s1_last_reg  <= op_kind != swfc_pkg::KIND_FREE;
            s1_a_reg     <= {1'b0, op_start} + (ADDR_BITS+1)'(cfg.header_bytes);
            s1_len_reg   <= op_end - op_start;
            s1_ge_reg    <= op_end >= op_start;
            s1_rel_reg   <= !cfg.exec_page && cfg.release_en
                            && op_kind == swfc_pkg::KIND_FREE;
        end
    end

    // Stage 2: align release bounds to the OS page, saturate length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_start_reg <= s1_start_reg;
            s2_len_reg   <= sat_len(s1_len_reg);
            s2_live_reg  <= s1_live_reg;
            s2_last_reg  <= s1_last_reg;
            s2_fill_reg  <= cfg.exec_page && s1_kind_reg == swfc_pkg::KIND_FREE;
            s2_chk_reg   <= s1_rel_reg && s1_ge_reg && !s1_a_reg[ADDR_BITS];
            s2_up_reg    <= (s1_a_reg + (ADDR_BITS+1)'(pg_mask))
                            & ~((ADDR_BITS+1)'(pg_mask));
            s2_down_reg  <= s1_end_reg & ~(ADDR_BITS'(pg_mask));
        end
    end

    // Output stage: release range only when aligned start lies below aligned end
    always_comb
    begin
        diff   = {1'b0, s2_down_reg} - {1'b0, s2_up_reg[ADDR_BITS-1:0]};
        rel_ok = s2_chk_reg && !s2_up_reg[ADDR_BITS] && !diff[ADDR_BITS]
                 && diff[ADDR_BITS-1:0] != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_ready)
        begin
            out_kind_reg   <= s2_kind_reg;
            out_start_reg  <= s2_start_reg;
            out_bytes_reg  <= s2_len_reg;
            out_fill_reg   <= s2_fill_reg;
            out_rstart_reg <= rel_ok ? s2_up_reg[ADDR_BITS-1:0] : '0;
            out_rbytes_reg <= rel_ok ? sat_len(diff[ADDR_BITS-1:0]) : '0;
            out_live_reg   <= s2_live_reg;
            out_last_reg   <= s2_last_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign kind          = out_kind_reg;
    assign block_start   = out_start_reg;
    assign block_bytes   = out_bytes_reg;
    assign fill_break    = out_fill_reg;
    assign release_start = out_rstart_reg;
    assign release_bytes = out_rbytes_reg;
    assign live_bytes    = out_live_reg;
    assign last          = out_last_reg;

    a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last == (kind != swfc_pkg::KIND_FREE)))
        else $error("page-end flag disagrees with result kind");

    a_release_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && release_bytes != '0 |->
            kind == swfc_pkg::KIND_FREE && !fill_break && release_start >= block_start)
        else $error("release range outside a releasable free block");

endmodule

`default_nettype wire

// ----- design/sweep_free_run_coalescer_top.sv -----
// Top level of the sweep free-run coalescer: front classifier, entry queue
// and back result pipeline. Depends on swfc_pkg, swfc_front, swfc_queue, swfc_back.
//
//  Channel  Handshake                  Payload
//  cfg      cfg_valid / cfg_ready      cfg_index, cfg_data
//  item     item_valid / item_ready    object_bytes, marked, page_last
//  result   result_valid / result_ready kind, block_start, block_bytes, fill_break,
//                                      release_start, release_bytes, live_bytes, last
//
// One item is accepted per cycle while the four-entry queue has room; an
// item yields zero, one or two requests on the result channel, one per cycle while result_ready allows.
// A result passes from the queue through the issue, align and output registers.
// An item yielding two results holds the queue head until both have been issued.
// Reset is asynchronous; configuration takes effect at once and a page_start
// write restarts the page. Result stalls back up through the queue to item_ready.
`default_nettype none

module sweep_free_run_coalescer_top #(
    parameter int ADDR_BITS = 48,
    parameter int SIZE_BITS = 32
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [swfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire  [ADDR_BITS-1:0]                cfg_data,
    input  wire                                 item_valid,
    output logic                                item_ready,
    input  wire  [SIZE_BITS-1:0]                object_bytes,
    input  wire                                 marked,
    input  wire                                 page_last,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output logic [1:0]                          kind,
    output logic [ADDR_BITS-1:0]                block_start,
    output logic [SIZE_BITS-1:0]                block_bytes,
    output logic                                fill_break,
    output logic [ADDR_BITS-1:0]                release_start,
    output logic [SIZE_BITS-1:0]                release_bytes,
    output logic [SIZE_BITS-1:0]                live_bytes,
    output logic                                last
);

    localparam int CTL_W = $bits(swfc_pkg::ctl_t);
    localparam int ENT_W = CTL_W + 2 * ADDR_BITS + SIZE_BITS;

    swfc_pkg::cfg_t       cfg;
    swfc_pkg::ctl_t       ent_ctl;
    swfc_pkg::ctl_t       q_ctl;
    logic [ADDR_BITS-1:0] ent_start;
    logic [ADDR_BITS-1:0] ent_end;
    logic [SIZE_BITS-1:0] ent_live;
    logic [ADDR_BITS-1:0] q_start;
    logic [ADDR_BITS-1:0] q_end;
    logic [SIZE_BITS-1:0] q_live;
    logic                 q_push;
    logic                 q_ready;
    logic                 q_pop;
    logic                 q_valid;
    logic [ENT_W-1:0]     q_head;

    swfc_front #(
        .ADDR_BITS(ADDR_BITS),
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .object_bytes (object_bytes),
        .marked       (marked),
        .page_last    (page_last),
        .cfg          (cfg),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .ent_ctl      (ent_ctl),
        .ent_start    (ent_start),
        .ent_end      (ent_end),
        .ent_live     (ent_live)
    );

    swfc_queue #(
        .WIDTH(ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({ent_ctl, ent_start, ent_end, ent_live}),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // Unpack the head entry
    assign {q_ctl, q_start, q_end, q_live} = q_head;

    swfc_back #(
        .ADDR_BITS(ADDR_BITS),
        .SIZE_BITS(SIZE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_ctl         (q_ctl),
        .q_start       (q_start),
        .q_end         (q_end),
        .q_live        (q_live),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .block_start   (block_start),
        .block_bytes   (block_bytes),
        .fill_break    (fill_break),
        .release_start (release_start),
        .release_bytes (release_bytes),
        .live_bytes    (live_bytes),
        .last          (last)
    );

endmodule

`default_nettype wire

// ----- test/tb_sweep_free_run_coalescer_top.sv -----
// Self-checking testbench for sweep_free_run_coalescer_top: directed pages, then random pages.
// Depends on swfc_pkg and the coalescer RTL; holds its own sweep predictor and result checker.
`timescale 1ns / 100ps

module tb_sweep_free_run_coalescer_top;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 32;
    localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_W) - 64'd1;
    localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_W) - 64'd1;
    localparam logic [ADDR_W-1:0] ADDR_TOP = '1;
    localparam logic [2:0] REG_FIRST_SPARE = swfc_pkg::REG_FREE_HEADER + 3'd1;
    localparam logic [2:0] REG_LAST_SPARE = '1;
    localparam int QUIET_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] block_start;
        logic [SIZE_W-1:0] block_bytes;
        logic              fill_break;
        logic [ADDR_W-1:0] release_start;
        logic [SIZE_W-1:0] release_bytes;
        logic [SIZE_W-1:0] live_bytes;
        logic              last;
    } sweep_result_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [swfc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [ADDR_W-1:0] cfg_data;
    logic item_valid;
    logic item_ready;
    logic [SIZE_W-1:0] object_bytes;
    logic marked;
    logic page_last;
    logic result_valid;
    logic result_ready;
    logic [1:0] kind;
    logic [ADDR_W-1:0] block_start;
    logic [SIZE_W-1:0] block_bytes;
    logic fill_break;
    logic [ADDR_W-1:0] release_start;
    logic [SIZE_W-1:0] release_bytes;
    logic [SIZE_W-1:0] live_bytes;
    logic last;

    // Sweep state and register copies
    logic [63:0] page_base;
    logic [63:0] cursor_addr;
    logic [63:0] run_base;
    logic run_open;
    logic [SIZE_W-1:0] live_total;
    logic exec_page;
    logic release_on;
    logic [4:0] os_log2;
    logic [7:0] header_bytes;

    sweep_result_t pending_results[$];
    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int report_count;
    int idle_cycles;

    sweep_free_run_coalescer_top #(
        .ADDR_BITS(ADDR_W),
        .SIZE_BITS(SIZE_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .object_bytes(object_bytes),
        .marked(marked),
        .page_last(page_last),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .kind(kind),
        .block_start(block_start),
        .block_bytes(block_bytes),
        .fill_break(fill_break),
        .release_start(release_start),
        .release_bytes(release_bytes),
        .live_bytes(live_bytes),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [SIZE_W-1:0] clamp_size(logic [63:0] v);
        return (v > SIZE_MAX) ? SIZE_MAX[SIZE_W-1:0] : v[SIZE_W-1:0];
    endfunction

    // Build a free block, with its releasable OS-page-aligned range
    function automatic sweep_result_t free_block_of(logic [63:0] bstart, logic [63:0] bend);
        sweep_result_t r;
        logic [63:0] pg;
        logic [63:0] hdr_end;
        logic [63:0] up;
        logic [63:0] down;
        r = '0;
        r.kind = swfc_pkg::KIND_FREE;
        r.block_start = bstart[ADDR_W-1:0];
        r.block_bytes = clamp_size((bend - bstart) & ADDR_MASK);
        r.fill_break = exec_page;
        if (!exec_page && release_on && bend >= bstart)
        begin
            pg = 64'd1 << os_log2;
            hdr_end = bstart + 64'(header_bytes);
            up = (hdr_end + pg - 64'd1) & ~(pg - 64'd1);
            down = bend & ~(pg - 64'd1);
            if (hdr_end >= bstart && up >= hdr_end && up < down)
            begin
                r.release_start = up[ADDR_W-1:0];
                r.release_bytes = clamp_size(down - up);
            end
        end
        return r;
    endfunction

    task automatic restart_page();
        cursor_addr = page_base;
        run_base = '0;
        run_open = 1'b0;
        live_total = '0;
    endtask

    task automatic apply_register(logic [2:0] idx, logic [ADDR_W-1:0] data);
        case (idx)
            swfc_pkg::REG_PAGE_START:
            begin
                page_base = 64'(data);
                restart_page();
            end
            swfc_pkg::REG_EXEC_PAGE:    exec_page = data[0];
            swfc_pkg::REG_RELEASE_EN:   release_on = data[0];
            swfc_pkg::REG_OS_PAGE_LOG2: os_log2 = data[4:0];
            swfc_pkg::REG_FREE_HEADER:  header_bytes = data[7:0];
            default: ;
        endcase
    endtask

    // Advance the sweep by one object and queue the results it closes
    task automatic predict_object(logic [SIZE_W-1:0] sz, logic mk, logic pl);
        logic [63:0] here;
        sweep_result_t r;
        here = cursor_addr;
        if (mk)
        begin
            if (run_open)
            begin
                pending_results.push_back(free_block_of(run_base, here));
                run_open = 1'b0;
            end
            live_total = clamp_size(64'(live_total) + 64'(sz));
        end
        else if (!run_open)
        begin
            run_base = here;
            run_open = 1'b1;
        end
        cursor_addr = (here + 64'(sz)) & ADDR_MASK;
        if (pl)
        begin
            if (run_open && run_base == page_base)
            begin
                r = '0;
                r.kind = swfc_pkg::KIND_WHOLE;
                r.block_start = run_base[ADDR_W-1:0];
                r.block_bytes = clamp_size((cursor_addr - run_base) & ADDR_MASK);
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            else
            begin
                if (run_open)
                    pending_results.push_back(free_block_of(run_base, cursor_addr));
                r = '0;
                r.kind = swfc_pkg::KIND_SUMMARY;
                r.live_bytes = live_total;
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            restart_page();
        end
    endtask

    // Offer one object request, with random idle cycles ahead of it
    task automatic send_object(logic [SIZE_W-1:0] sz, logic mk, logic pl);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        predict_object(sz, mk, pl);
        object_bytes = sz;
        marked = mk;
        page_last = pl;
        item_valid = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every pending result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [ADDR_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] pick_page_start();
        logic [ADDR_W-1:0] word;
        word = ADDR_W'({$urandom, $urandom});
        case ($urandom_range(3))
            0: return word;
            1: return ADDR_TOP - ADDR_W'($urandom_range(0, 65535));
            2: return word & ~ADDR_W'(32'hFFFFF);
            default: return ADDR_W'($urandom_range(0, 4095)) << 12;
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_object_size(int scale);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return $urandom;
        if (roll < 5)
            return SIZE_W'($urandom_range(0, 7));
        if (roll < 6)
            return '1;
        case (scale)
            0: return SIZE_W'(8 * $urandom_range(1, 64));
            1: return SIZE_W'(8 * $urandom_range(1, 16384));
            default: return SIZE_W'(8 * $urandom_range(1, 1 << 20));
        endcase
    endfunction

    // Rewrite a random subset of the registers; call only while idle
    task automatic shuffle_settings();
        logic [ADDR_W-1:0] word;
        logic [7:0] hdr;
        word = ADDR_W'({$urandom, $urandom});
        if ($urandom_range(99) < 60)
            write_register(swfc_pkg::REG_PAGE_START, pick_page_start());
        if ($urandom_range(99) < 50)
            write_register(swfc_pkg::REG_EXEC_PAGE,
                           {word[ADDR_W-1:1], 1'($urandom_range(99) < 25)});
        if ($urandom_range(99) < 50)
            write_register(swfc_pkg::REG_RELEASE_EN,
                           {word[ADDR_W-1:1], 1'($urandom_range(99) < 75)});
        if ($urandom_range(99) < 50)
        begin
            if ($urandom_range(99) < 80)
                write_register(swfc_pkg::REG_OS_PAGE_LOG2,
                               {word[ADDR_W-1:5], 5'($urandom_range(12, 21))});
            else
                write_register(swfc_pkg::REG_OS_PAGE_LOG2,
                               {word[ADDR_W-1:5], 5'($urandom_range(0, 31))});
        end
        if ($urandom_range(99) < 50)
        begin
            case ($urandom_range(3))
                0: hdr = '0;
                1: hdr = '1;
                default: hdr = 8'($urandom_range(0, 255));
            endcase
            write_register(swfc_pkg::REG_FREE_HEADER, {word[ADDR_W-1:8], hdr});
        end
        if ($urandom_range(99) < 5)
            write_register(3'($urandom_range(int'(REG_LAST_SPARE), int'(REG_FIRST_SPARE))),
                           ADDR_W'({$urandom, $urandom}));
    endtask

    // Hold result_ready low on random cycles
    always @(negedge clk)
    begin
        result_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (report_count < MAX_REPORTS)
            begin
                report_count++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        sweep_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                begin
                    report_count++;
                    $display("%0t: unexpected result, expected none actual kind %0d start %0h",
                             $time, kind, block_start);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(kind));
                check_field("block_start", 64'(want.block_start), 64'(block_start));
                check_field("block_bytes", 64'(want.block_bytes), 64'(block_bytes));
                check_field("fill_break", 64'(want.fill_break), 64'(fill_break));
                check_field("release_start", 64'(want.release_start), 64'(release_start));
                check_field("release_bytes", 64'(want.release_bytes), 64'(release_bytes));
                check_field("live_bytes", 64'(want.live_bytes), 64'(live_bytes));
                check_field("last", 64'(want.last), 64'(last));
            end
        end
    end

    // End the run when no channel moves for too long
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (cfg_valid && cfg_ready) ||
            (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Runs of garbage around a live object with reset settings
    task automatic test_default_coalescing();
        send_object(64, 1'b0, 1'b0);
        send_object(24, 1'b0, 1'b0);
        send_object(16, 1'b1, 1'b0);
        send_object(40, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_release_range();
        write_register(swfc_pkg::REG_RELEASE_EN, 48'd1);
        write_register(swfc_pkg::REG_OS_PAGE_LOG2, 48'd12);
        write_register(swfc_pkg::REG_FREE_HEADER, 48'd32);
        write_register(swfc_pkg::REG_PAGE_START, 48'h1000);
        send_object(32'h3000, 1'b0, 1'b0);
        send_object(8, 1'b1, 1'b1);
        wait_idle();
    endtask

    // Code pages fill with break and never release
    task automatic test_executable_page();
        write_register(swfc_pkg::REG_EXEC_PAGE, 48'd1);
        send_object(32'h3000, 1'b0, 1'b0);
        send_object(8, 1'b1, 1'b1);
        wait_idle();
        write_register(swfc_pkg::REG_EXEC_PAGE, 48'd0);
    endtask

    // A block that wraps past the top of the address space
    task automatic test_address_wrap();
        write_register(swfc_pkg::REG_PAGE_START, 48'hFFFF_FFFF_FFF0);
        send_object(32, 1'b0, 1'b0);
        send_object(8, 1'b1, 1'b0);
        send_object(8, 1'b0, 1'b1);
        wait_idle();
    endtask

    // Saturate the live total, then a block and its release length
    task automatic test_saturation();
        write_register(swfc_pkg::REG_PAGE_START, 48'd0);
        write_register(swfc_pkg::REG_FREE_HEADER, 48'd0);
        send_object('1, 1'b1, 1'b0);
        send_object('1, 1'b1, 1'b1);
        send_object('1, 1'b0, 1'b0);
        send_object('1, 1'b0, 1'b0);
        send_object(8, 1'b1, 1'b1);
        wait_idle();
    endtask

    // OS page sizes of one byte and of 2 GiB
    task automatic test_odd_os_page();
        write_register(swfc_pkg::REG_OS_PAGE_LOG2, 48'd0);
        write_register(swfc_pkg::REG_FREE_HEADER, 48'd5);
        write_register(swfc_pkg::REG_PAGE_START, 48'h40);
        send_object(100, 1'b0, 1'b0);
        send_object(8, 1'b1, 1'b1);
        wait_idle();
        write_register(swfc_pkg::REG_OS_PAGE_LOG2, 48'd31);
        write_register(swfc_pkg::REG_FREE_HEADER, 48'd255);
        write_register(swfc_pkg::REG_PAGE_START, 48'h7FFF_F000);
        send_object(32'h8000_1000, 1'b0, 1'b0);
        send_object(8, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_tiny_sizes();
        write_register(swfc_pkg::REG_OS_PAGE_LOG2, 48'd12);
        write_register(swfc_pkg::REG_PAGE_START, 48'h100);
        send_object(0, 1'b0, 1'b0);
        send_object(1, 1'b0, 1'b0);
        send_object(3, 1'b1, 1'b1);
        wait_idle();
    endtask

    // Abandon a page midway; a spare index must change nothing
    task automatic test_page_restart();
        send_object(64, 1'b0, 1'b0);
        send_object(8, 1'b1, 1'b0);
        wait_idle();
        write_register(REG_FIRST_SPARE, 48'hFFFF_FFFF_FFFF);
        write_register(swfc_pkg::REG_PAGE_START, 48'h2000);
        send_object(8, 1'b0, 1'b1);
        wait_idle();
    endtask

    // Mostly whole pages with random content, some cut short by a restart
    task automatic test_random_pages(int send_pct, int recv_pct, int budget);
        int sent;
        int n_objs;
        int scale;
        int mark_pct;
        bit all_free;
        bit broken;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(99) < 30)
            begin
                wait_idle();
                shuffle_settings();
            end
            else if ($urandom_range(99) < 3)
                wait_idle();
            n_objs = $urandom_range(1, 12);
            scale = $urandom_range(2);
            mark_pct = $urandom_range(10, 90);
            all_free = ($urandom_range(99) < 12);
            broken = ($urandom_range(99) < 8);
            for (int i = 0; i < n_objs; i++)
            begin
                send_object(pick_object_size(scale),
                            all_free ? 1'b0 : 1'($urandom_range(99) < mark_pct),
                            (i == n_objs - 1) && !broken);
                sent++;
            end
            if (broken)
            begin
                wait_idle();
                write_register(swfc_pkg::REG_PAGE_START, pick_page_start());
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_valid = 1'b0;
        object_bytes = '0;
        marked = 1'b0;
        page_last = 1'b0;
        result_ready = 1'b0;
        fail_count = 0;
        report_count = 0;
        idle_cycles = 0;
        send_idle_pct = 18;
        recv_idle_pct = 68;
        page_base = '0;
        exec_page = 1'b0;
        release_on = 1'b0;
        os_log2 = swfc_pkg::OS_PAGE_LOG2_RESET;
        header_bytes = swfc_pkg::FREE_HEADER_RESET;
        restart_page();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_coalescing();
        test_release_range();
        test_executable_page();
        test_address_wrap();
        test_saturation();
        test_odd_os_page();
        test_tiny_sizes();
        test_page_restart();
        test_random_pages(18, 68, 500);
        test_random_pages(68, 18, 500);
        test_random_pages(0, 0, 450);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
